FILE: hdl/swerm_pkg.sv
package swerm_pkg;

   // ring size used when the top level is not overridden
   localparam int RING_DEPTH_DEF = 1024;

   // field widths fixed by the interface
   localparam int NOW_W  = 48;
   localparam int MIN_W  = 6;
   localparam int RATE_W = 11;
   localparam int SPAN_W = 32;
   localparam int DEN_W  = MIN_W + 1;

   // register indexes on the csr port
   localparam logic [1:0] CSR_WIN_A = 2'd0;
   localparam logic [1:0] CSR_WIN_B = 2'd1;
   localparam logic [1:0] CSR_WIN_C = 2'd2;
   localparam logic [1:0] CSR_KEEP  = 2'd3;

   // reset values of the registers
   localparam logic [MIN_W-1:0] WIN_A_RST = 6'd1;
   localparam logic [MIN_W-1:0] WIN_B_RST = 6'd3;
   localparam logic [MIN_W-1:0] WIN_C_RST = 6'd5;
   localparam logic [MIN_W-1:0] KEEP_RST  = 6'd5;

   localparam logic [SPAN_W-1:0] US_PER_MINUTE = 32'd60000000;

   // minutes to microseconds (63 minutes still fits 32 bits)
   function automatic logic [SPAN_W-1:0] span_of(input logic [MIN_W-1:0] minutes);
      return SPAN_W'(minutes) * US_PER_MINUTE;
   endfunction

   // a zero window counts as one minute
   function automatic logic [MIN_W-1:0] win_eff(input logic [MIN_W-1:0] minutes);
      return (minutes == '0) ? MIN_W'(1) : minutes;
   endfunction

endpackage

FILE: hdl/swerm_ring.sv
module swerm_ring #(
   parameter int DEPTH = swerm_pkg::RING_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [$clog2(DEPTH)-1:0]               wr_addr,
   input  logic [swerm_pkg::NOW_W-1:0]            wr_data,
   input  logic [$clog2(DEPTH)-1:0]               rd_addr,
   output logic [swerm_pkg::NOW_W-1:0]            rd_data
);
   import swerm_pkg::*;

   logic [NOW_W-1:0] mem [DEPTH];
   logic [NOW_W-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/swerm_div.sv
module swerm_div #(
   parameter int NW = 19
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [NW-1:0]                 num,
   input  logic [swerm_pkg::DEN_W-1:0]   den,
   output logic                          done,
   output logic [NW-1:0]                 quot
);
   import swerm_pkg::*;

   localparam int CNT_W = $clog2(NW + 1);

   logic [DEN_W-1:0] rem_ff;
   logic [NW-1:0]    dvd_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic             fits;

   // restoring division, one quotient bit per cycle
   assign trial = {rem_ff, dvd_ff[NW-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NW);
            rem_ff  <= '0;
            dvd_ff  <= num;
            den_ff  <= den;
         end else if (busy_ff) begin
            rem_ff <= fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            dvd_ff <= {dvd_ff[NW-2:0], fits};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = dvd_ff;

endmodule

FILE: hdl/sliding_window_event_rate_meter_top.sv
// Record request: drops stamps from the oldest end, reading one per cycle and stopping at
//   the first kept one or when every held stamp is dropped, then appends the new stamp.
// Query request: reads every held stamp, one per cycle, counting those inside each window,
//   then divides for each window in turn on count width + 2 bits, one quotient bit per cycle.
// One request at a time, the next taken once the previous one finishes, even while its
//   response waits in the output register. Sync reset clears pointers, count and registers.
module sliding_window_event_rate_meter_top #(
   parameter int RING_DEPTH = swerm_pkg::RING_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [swerm_pkg::NOW_W-1:0]       req_now_us,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [swerm_pkg::RATE_W-1:0]      rsp_rate_a,
   output logic [swerm_pkg::RATE_W-1:0]      rsp_rate_b,
   output logic [swerm_pkg::RATE_W-1:0]      rsp_rate_c,
   output logic [swerm_pkg::RATE_W-1:0]      rsp_entries_held,
   input  logic                              csr_wr_en,
   input  logic [1:0]                        csr_index,
   input  logic [swerm_pkg::MIN_W-1:0]       csr_wdata
);
   import swerm_pkg::*;

   localparam int AW = $clog2(RING_DEPTH);
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int NW = CW + 2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DROP_SCAN,
      ST_DROP_FIN,
      ST_WRITE,
      ST_Q_SCAN,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_RESP
   } state_type;

   state_type        state_ff;
   logic             kind_ff;
   logic [NOW_W-1:0] now_ff;
   logic [AW-1:0]    oldest_ff;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    iss_ff;
   logic             pend_ff;
   logic [CW-1:0]    drop_n_ff;
   logic [CW-1:0]    cnt_a_ff;
   logic [CW-1:0]    cnt_b_ff;
   logic [CW-1:0]    cnt_c_ff;
   logic [1:0]       sel_ff;

   logic [MIN_W-1:0] win_a_ff;
   logic [MIN_W-1:0] win_b_ff;
   logic [MIN_W-1:0] win_c_ff;
   logic [MIN_W-1:0] keep_ff;
   logic [SPAN_W-1:0] span_a_ff;
   logic [SPAN_W-1:0] span_b_ff;
   logic [SPAN_W-1:0] span_c_ff;
   logic [SPAN_W-1:0] span_k_ff;

   logic             drop_en_ff;
   logic [NOW_W-1:0] limit_ff;
   logic             all_a_ff;
   logic             all_b_ff;
   logic             all_c_ff;
   logic [NOW_W-1:0] thr_a_ff;
   logic [NOW_W-1:0] thr_b_ff;
   logic [NOW_W-1:0] thr_c_ff;

   logic [RATE_W-1:0] res_a_ff;
   logic [RATE_W-1:0] res_b_ff;
   logic [RATE_W-1:0] res_c_ff;

   logic              rsp_valid_ff;
   logic [RATE_W-1:0] rate_a_ff;
   logic [RATE_W-1:0] rate_b_ff;
   logic [RATE_W-1:0] rate_c_ff;
   logic [RATE_W-1:0] held_ff;

   logic             ring_we;
   logic [AW-1:0]    ring_waddr;
   logic [AW-1:0]    ring_raddr;
   logic [NOW_W-1:0] ring_rdata;
   logic             issue;
   logic             full;

   logic             div_start;
   logic             div_done;
   logic [NW-1:0]    div_num;
   logic [DEN_W-1:0] div_den;
   logic [NW-1:0]    div_quot;
   logic [CW-1:0]    sel_cnt;
   logic [MIN_W-1:0] sel_min;
   logic [RATE_W-1:0] rate_sat;
   logic [NW+RATE_W-1:0] quot_ext;
   logic [CW+RATE_W-1:0] count_ext;

   // ring position a + b, with a < depth and b <= depth
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      s = (CW+1)'(a) + (CW+1)'(b);
      if (s >= (CW+1)'(RING_DEPTH)) begin
         s = s - (CW+1)'(RING_DEPTH);
      end
      return s[AW-1:0];
   endfunction

   // stamp memory
   swerm_ring #(
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (now_ff),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   // shared rounding divider
   swerm_div #(
      .NW (NW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // memory addressing
   assign full       = (count_ff == CW'(RING_DEPTH));
   assign issue      = (iss_ff != count_ff);
   assign ring_raddr = wrap_add(oldest_ff, iss_ff);
   assign ring_we    = (state_ff == ST_WRITE);
   assign ring_waddr = full ? oldest_ff : wrap_add(oldest_ff, count_ff);

   // divider operands: floor((2N + m) / (2m))
   always_comb begin
      unique case (sel_ff)
         2'd0: begin
            sel_cnt = cnt_a_ff;
            sel_min = win_eff(win_a_ff);
         end
         2'd1: begin
            sel_cnt = cnt_b_ff;
            sel_min = win_eff(win_b_ff);
         end
         default: begin
            sel_cnt = cnt_c_ff;
            sel_min = win_eff(win_c_ff);
         end
      endcase
   end

   assign div_start = (state_ff == ST_DIV_GO);
   assign div_num   = {1'b0, sel_cnt, 1'b0} + NW'(sel_min);
   assign div_den   = {sel_min, 1'b0};

   // saturate the quotient to the rate width
   assign quot_ext  = {{RATE_W{1'b0}}, div_quot};
   assign rate_sat  = (|quot_ext[NW+RATE_W-1:RATE_W]) ? {RATE_W{1'b1}} : quot_ext[RATE_W-1:0];
   assign count_ext = {{RATE_W{1'b0}}, count_ff};

   // window spans in microseconds, refreshed from the registers
   always_ff @(posedge clock) begin
      span_a_ff <= span_of(win_eff(win_a_ff));
      span_b_ff <= span_of(win_eff(win_b_ff));
      span_c_ff <= span_of(win_eff(win_c_ff));
      span_k_ff <= span_of(keep_ff);
   end

   // per-request thresholds
   always_ff @(posedge clock) begin
      if (state_ff == ST_SETUP) begin
         drop_en_ff <= (now_ff >= NOW_W'(span_k_ff));
         limit_ff   <= now_ff - NOW_W'(span_k_ff);
         all_a_ff   <= (now_ff < NOW_W'(span_a_ff));
         all_b_ff   <= (now_ff < NOW_W'(span_b_ff));
         all_c_ff   <= (now_ff < NOW_W'(span_c_ff));
         thr_a_ff   <= now_ff - NOW_W'(span_a_ff);
         thr_b_ff   <= now_ff - NOW_W'(span_b_ff);
         thr_c_ff   <= now_ff - NOW_W'(span_c_ff);
      end
   end

   // sequencer, ring pointers, registers and response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         iss_ff       <= '0;
         pend_ff      <= 1'b0;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         win_a_ff     <= WIN_A_RST;
         win_b_ff     <= WIN_B_RST;
         win_c_ff     <= WIN_C_RST;
         keep_ff      <= KEEP_RST;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_WIN_A: win_a_ff <= csr_wdata;
               CSR_WIN_B: win_b_ff <= csr_wdata;
               CSR_WIN_C: win_c_ff <= csr_wdata;
               CSR_KEEP:  keep_ff  <= csr_wdata;
               default:   ;
            endcase
         end

         // response taken; a reload in ST_RESP handles its own valid
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  kind_ff  <= req_kind;
                  now_ff   <= req_now_us;
                  state_ff <= ST_SETUP;
               end
            end

            ST_SETUP: begin
               iss_ff    <= '0;
               pend_ff   <= 1'b0;
               drop_n_ff <= '0;
               cnt_a_ff  <= '0;
               cnt_b_ff  <= '0;
               cnt_c_ff  <= '0;
               sel_ff    <= '0;
               state_ff  <= kind_ff ? ST_Q_SCAN : ST_DROP_SCAN;
            end

            // drop from the oldest end while stamps are not newer than the limit
            ST_DROP_SCAN: begin
               if (!drop_en_ff || (pend_ff && ring_rdata > limit_ff)) begin
                  pend_ff  <= 1'b0;
                  state_ff <= ST_DROP_FIN;
               end else begin
                  if (pend_ff) begin
                     drop_n_ff <= drop_n_ff + CW'(1);
                  end
                  pend_ff <= issue;
                  if (issue) begin
                     iss_ff <= iss_ff + CW'(1);
                  end else if (!pend_ff) begin
                     state_ff <= ST_DROP_FIN;
                  end
               end
            end

            ST_DROP_FIN: begin
               oldest_ff <= wrap_add(oldest_ff, drop_n_ff);
               count_ff  <= count_ff - drop_n_ff;
               state_ff  <= ST_WRITE;
            end

            // append, overwriting the oldest when full
            ST_WRITE: begin
               if (full) begin
                  oldest_ff <= wrap_add(oldest_ff, CW'(1));
               end else begin
                  count_ff <= count_ff + CW'(1);
               end
               state_ff <= ST_IDLE;
            end

            // count stamps inside each window
            ST_Q_SCAN: begin
               if (pend_ff) begin
                  if (all_a_ff || ring_rdata >= thr_a_ff) cnt_a_ff <= cnt_a_ff + CW'(1);
                  if (all_b_ff || ring_rdata >= thr_b_ff) cnt_b_ff <= cnt_b_ff + CW'(1);
                  if (all_c_ff || ring_rdata >= thr_c_ff) cnt_c_ff <= cnt_c_ff + CW'(1);
               end
               pend_ff <= issue;
               if (issue) begin
                  iss_ff <= iss_ff + CW'(1);
               end else if (!pend_ff) begin
                  state_ff <= ST_DIV_GO;
               end
            end

            ST_DIV_GO: begin
               state_ff <= ST_DIV_WAIT;
            end

            // rates collect here so a waiting response stays untouched
            ST_DIV_WAIT: begin
               if (div_done) begin
                  unique case (sel_ff)
                     2'd0:    res_a_ff <= rate_sat;
                     2'd1:    res_b_ff <= rate_sat;
                     default: res_c_ff <= rate_sat;
                  endcase
                  if (sel_ff == 2'd2) begin
                     state_ff <= ST_RESP;
                  end else begin
                     sel_ff   <= sel_ff + 2'd1;
                     state_ff <= ST_DIV_GO;
                  end
               end
            end

            // hand over once the output register is free
            ST_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rate_a_ff    <= res_a_ff;
                  rate_b_ff    <= res_b_ff;
                  rate_c_ff    <= res_c_ff;
                  held_ff      <= count_ext[RATE_W-1:0];
                  state_ff     <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rate_a       = rate_a_ff;
   assign rsp_rate_b       = rate_b_ff;
   assign rsp_rate_c       = rate_c_ff;
   assign rsp_entries_held = held_ff;

endmodule
